@@ hw/rtl/gsst_pkg.sv @@
package gsst_pkg;

    // Event kinds
    localparam logic [2:0] K_LAUNCH    = 3'd0;
    localparam logic [2:0] K_KDONE     = 3'd1;
    localparam logic [2:0] K_COPY_H2D  = 3'd2;
    localparam logic [2:0] K_COPY_D2H  = 3'd3;
    localparam logic [2:0] K_COPY_D2D  = 3'd4;
    localparam logic [2:0] K_SYNC_DEV  = 3'd5;
    localparam logic [2:0] K_SYNC_STRM = 3'd6;
    localparam logic [2:0] K_IGNORE    = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_QUEUED   = 3'd1,
        ST_RUNNING  = 3'd2,
        ST_WAITING  = 3'd3,
        ST_COMPLETE = 3'd4
    } t_slot_st;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [2:0]  device_num;
        logic [4:0]  stream_num;
        logic [63:0] event_time;
        logic [63:0] event_duration;
        logic [63:0] correlation_tag;
    } t_req;

    typedef struct packed {
        logic [2:0]  out_device;
        logic [4:0]  out_stream;
        logic [2:0]  from_state;
        logic [2:0]  to_state;
        logic [63:0] transition_time;
        logic [63:0] out_correlation;
        logic [63:0] busy_total;
        logic [63:0] tracked_total;
        logic        last_of_run;
    } t_res;

    // One slot table entry
    typedef struct packed {
        t_slot_st    state;
        logic        seen;
        logic [63:0] last_time;
        logic [63:0] busy_time;
        logic [63:0] sum_time;
    } t_entry;

    // Transition plan of one event: up to three steps
    typedef struct packed {
        logic [2:0]           emit;
        logic [2:0]           use_end;
        t_slot_st [2:0]       nxt;
    } t_plan;

endpackage

@@ hw/rtl/gpu_stream_state_tracker_top.sv @@
// Channel   Handshake             Payload   Direction
// event     start / busy          i_req     in
// result    o_res_valid (strobe)  o_res     out
//
// Each event has a slot table read, a plan step, then one step per transition
// emitted (n = 0..3) through the shared 64-bit time accumulate; the entry is
// written back with the last transition. After reset a clearing pass writes
// every slot with busy high. Results are one-cycle strobes; the receiver cannot stall.
module gpu_stream_state_tracker_top #(
    parameter int DEVICE_BITS = 3,
    parameter int STREAM_BITS = 5
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  gsst_pkg::t_req  i_req,
    output logic            o_res_valid,
    output gsst_pkg::t_res  o_res
);

    localparam int SLOT_BITS  = DEVICE_BITS + STREAM_BITS;
    localparam int SLOT_COUNT = 1 << SLOT_BITS;
    localparam int WIDE_BITS  = SLOT_BITS + 3;
    localparam int DMASK      = (1 << DEVICE_BITS) - 1;
    localparam int SMASK      = (1 << STREAM_BITS) - 1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_STEP
    } t_fsm;

    t_fsm                  r_fsm;
    logic [SLOT_BITS-1:0]  r_clr;
    logic [SLOT_BITS-1:0]  r_slot;
    gsst_pkg::t_req        r_req;
    logic [63:0]           r_end;
    gsst_pkg::t_entry      r_rd;
    gsst_pkg::t_entry      r_mem [SLOT_COUNT];
    gsst_pkg::t_plan       r_plan;
    gsst_pkg::t_slot_st    r_st;
    logic                  r_seen;
    logic [63:0]           r_last;
    logic [63:0]           r_busy;
    logic [63:0]           r_total;

    logic                  w_accept;
    logic [WIDE_BITS-1:0]  w_wide;
    logic [SLOT_BITS-1:0]  w_slot;
    gsst_pkg::t_plan       w_plan;
    logic [1:0]            w_idx;
    logic [2:0]            n_emit;
    gsst_pkg::t_slot_st    n_st;
    logic [63:0]           n_when;
    logic [63:0]           n_busy;
    logic [63:0]           n_total;
    logic                  w_last;
    logic                  w_we;
    logic [SLOT_BITS-1:0]  w_waddr;
    gsst_pkg::t_entry      w_wdata;

    assign busy     = (r_fsm != S_IDLE);
    assign w_accept = start && !busy;

    // Bits above DEVICE_BITS / STREAM_BITS are dropped for slot selection
    assign w_wide = ((WIDE_BITS'(i_req.device_num) & WIDE_BITS'(DMASK)) << STREAM_BITS)
                  | (WIDE_BITS'(i_req.stream_num) & WIDE_BITS'(SMASK));
    assign w_slot = w_wide[SLOT_BITS-1:0];

    gsst_plan u_plan (
        .i_kind   (r_req.req_type),
        .i_state  (r_rd.state),
        .i_dur_nz (r_req.event_duration != 64'd0),
        .o_plan   (w_plan)
    );

    // Take the lowest pending step
    always_comb begin
        case (r_plan.emit)
            3'b000, 3'b100: w_idx = 2'd2;
            3'b010, 3'b110: w_idx = 2'd1;
            default:        w_idx = 2'd0;
        endcase
    end

    always_comb begin
        case (w_idx)
            2'd0:    n_emit = r_plan.emit & 3'b110;
            2'd1:    n_emit = r_plan.emit & 3'b100;
            default: n_emit = 3'b000;
        endcase
    end

    assign w_last = (n_emit == 3'b000);
    assign n_st   = r_plan.nxt[w_idx];
    assign n_when = r_plan.use_end[w_idx] ? r_end : r_req.event_time;

    // Credit the gap since the previous transition to the state being left
    assign n_total = r_seen ? (r_total + n_when - r_last) : r_total;
    assign n_busy  = (r_seen && (r_st != gsst_pkg::ST_IDLE)) ?
                     (r_busy + n_when - r_last) : r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= S_CLEAR;
            r_clr       <= '0;
            r_plan      <= '0;
            o_res_valid <= 1'b0;
        end else begin
            o_res_valid <= 1'b0;
            unique case (r_fsm)
                S_CLEAR: begin
                    r_clr <= r_clr + SLOT_BITS'(1);
                    if (r_clr == '1) begin
                        r_fsm <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_req  <= i_req;
                        r_slot <= w_slot;
                        r_end  <= i_req.event_time + i_req.event_duration;
                        r_fsm  <= S_READ;
                    end
                end
                S_READ: begin
                    r_plan  <= w_plan;
                    r_st    <= r_rd.state;
                    r_seen  <= r_rd.seen;
                    r_last  <= r_rd.last_time;
                    r_busy  <= r_rd.busy_time;
                    r_total <= r_rd.sum_time;
                    r_fsm   <= (w_plan.emit == 3'b000) ? S_IDLE : S_STEP;
                end
                S_STEP: begin
                    r_plan.emit <= n_emit;
                    r_st        <= n_st;
                    r_seen      <= 1'b1;
                    r_last      <= n_when;
                    r_busy      <= n_busy;
                    r_total     <= n_total;
                    o_res_valid <= 1'b1;
                    o_res.out_device      <= r_req.device_num;
                    o_res.out_stream      <= r_req.stream_num;
                    o_res.from_state      <= r_st;
                    o_res.to_state        <= n_st;
                    o_res.transition_time <= n_when;
                    o_res.out_correlation <= r_req.correlation_tag;
                    o_res.busy_total      <= n_busy;
                    o_res.tracked_total   <= n_total;
                    o_res.last_of_run     <= w_last;
                    if (w_last) begin
                        r_fsm <= S_IDLE;
                    end
                end
                default: begin
                    r_fsm <= S_CLEAR;
                end
            endcase
        end
    end

    // Slot table: clear sweep after reset, write back on the last transition
    assign w_we    = (r_fsm == S_CLEAR) || ((r_fsm == S_STEP) && w_last);
    assign w_waddr = (r_fsm == S_CLEAR) ? r_clr : r_slot;

    always_comb begin
        w_wdata = '0;
        if (r_fsm == S_STEP) begin
            w_wdata.state     = n_st;
            w_wdata.seen      = 1'b1;
            w_wdata.last_time = n_when;
            w_wdata.busy_time = n_busy;
            w_wdata.sum_time  = n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_accept) begin
            r_rd <= r_mem[w_slot];
        end
    end

    a_res_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> ($past(r_fsm) == S_STEP))
        else $error("result strobe without a transition step");

    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_fsm == S_READ))
        else $error("accepted event did not start a slot read");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.last_of_run) |=> !o_res_valid)
        else $error("result after the last transition of an event");

    a_real_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_res.from_state != o_res.to_state))
        else $error("transition to the state already held");

    a_write_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == S_STEP && w_last) |=> (r_fsm == S_IDLE && o_res.last_of_run))
        else $error("write back out of step with the last transition");

endmodule

@@ hw/rtl/gsst_plan.sv @@
module gsst_plan (
    input  logic [2:0]        i_kind,
    input  gsst_pkg::t_slot_st i_state,
    input  logic              i_dur_nz,
    output gsst_pkg::t_plan   o_plan
);

    // The slot state only moves along the planned targets, so each step's
    // emit decision follows from the state at the start of the event.
    always_comb begin
        o_plan = '0;
        unique case (i_kind) inside
            gsst_pkg::K_LAUNCH: begin
                o_plan.emit[0] = (i_state == gsst_pkg::ST_IDLE);
                o_plan.nxt[0]  = gsst_pkg::ST_QUEUED;
                o_plan.emit[1] = (i_state == gsst_pkg::ST_IDLE) ||
                                 (i_state != gsst_pkg::ST_RUNNING);
                o_plan.nxt[1]  = gsst_pkg::ST_RUNNING;
            end
            gsst_pkg::K_KDONE: begin
                o_plan.emit[0]    = (i_state != gsst_pkg::ST_COMPLETE);
                o_plan.nxt[0]     = gsst_pkg::ST_COMPLETE;
                o_plan.emit[1]    = 1'b1;
                o_plan.nxt[1]     = gsst_pkg::ST_IDLE;
                o_plan.use_end[1] = 1'b1;
            end
            [gsst_pkg::K_COPY_H2D:gsst_pkg::K_COPY_D2D]: begin
                o_plan.emit[0]    = (i_state == gsst_pkg::ST_IDLE);
                o_plan.nxt[0]     = gsst_pkg::ST_RUNNING;
                o_plan.emit[1]    = i_dur_nz && (i_state != gsst_pkg::ST_COMPLETE);
                o_plan.nxt[1]     = gsst_pkg::ST_COMPLETE;
                o_plan.use_end[1] = 1'b1;
                o_plan.emit[2]    = i_dur_nz;
                o_plan.nxt[2]     = gsst_pkg::ST_IDLE;
                o_plan.use_end[2] = 1'b1;
            end
            gsst_pkg::K_SYNC_DEV, gsst_pkg::K_SYNC_STRM: begin
                o_plan.emit[0]    = (i_state != gsst_pkg::ST_WAITING);
                o_plan.nxt[0]     = gsst_pkg::ST_WAITING;
                o_plan.emit[1]    = 1'b1;
                o_plan.nxt[1]     = gsst_pkg::ST_IDLE;
                o_plan.use_end[1] = 1'b1;
            end
            default: begin
                o_plan = '0;
            end
        endcase
    end

endmodule
